[rtl/tbs_pkg.sv]
// Shared constants, types and codes of the bilinear texture sampler.
`timescale 1ns / 1ps
`default_nettype none

package tbs_pkg;

  // Texture and number formats
  localparam int MAX_DIM         = 256;
  localparam int CHANNEL_BITS    = 16;
  localparam int COORD_FRAC_BITS = 16;
  localparam int DIM_BITS        = 9;
  localparam int IDX_BITS        = $clog2(MAX_DIM);
  localparam int COORD_BITS      = COORD_FRAC_BITS + 1;
  localparam int POS_BITS        = COORD_BITS + IDX_BITS;
  localparam int ADDR_BITS       = 16;
  localparam int BANK_ADDR_BITS  = ADDR_BITS - 1;
  localparam int BANK_DEPTH      = 2 ** BANK_ADDR_BITS;
  localparam int TEXEL_BITS      = 3 * CHANNEL_BITS;
  localparam int WT_BITS         = 2 * COORD_FRAC_BITS + 1;
  localparam int PROD_BITS       = CHANNEL_BITS + 2 * COORD_FRAC_BITS;
  localparam int MUL_BITS        = CHANNEL_BITS + WT_BITS;

  // Register port
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [DIM_BITS-1:0]   DIM_RESET  = DIM_BITS'(256);
  localparam logic [DIM_BITS-1:0]   DIM_MAX    = DIM_BITS'(MAX_DIM);
  localparam logic [DIM_BITS-1:0]   DIM_MIN    = DIM_BITS'(1);
  localparam logic [COORD_BITS-1:0] ONE_COORD  = COORD_BITS'(2 ** COORD_FRAC_BITS);
  localparam logic [POS_BITS-1:0]   HALF_POS   = POS_BITS'(2 ** (COORD_FRAC_BITS - 1));
  localparam logic [WT_BITS-1:0]    WT_ONE     = {1'b1, {(2 * COORD_FRAC_BITS){1'b0}}};
  localparam logic [PROD_BITS-1:0]  ROUND_HALF =
    {{(PROD_BITS - 2 * COORD_FRAC_BITS){1'b0}}, 1'b1, {(2 * COORD_FRAC_BITS - 1){1'b0}}};

  // Item and mode codes
  localparam logic OP_WRITE      = 1'b0;
  localparam logic OP_SAMPLE     = 1'b1;
  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  // Channel slots inside a packed texel
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  typedef enum logic [CFG_ADDR_BITS-3:0] {
    REG_TEX_WIDTH   = 2'd0,
    REG_TEX_HEIGHT  = 2'd1,
    REG_FILTER_MODE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] tex_width;
    logic [DIM_BITS-1:0] tex_height;
    logic                filter_mode;
  } cfg_t;

  // One memory access plus the blend sideband of a sample
  typedef struct packed {
    logic                                op;
    logic [ADDR_BITS-1:0]                waddr;
    logic [TEXEL_BITS-1:0]               wdata;
    logic [1:0][BANK_ADDR_BITS-1:0]      even_addr;
    logic [1:0][BANK_ADDR_BITS-1:0]      odd_addr;
    logic [1:0]                          base_odd;
    logic                                frac_x;
    logic [3:0][WT_BITS-1:0]             wt;
  } issue_t;

endpackage

`default_nettype wire

[rtl/tbs_store.sv]
// Parity-banked texel store: even and odd addresses, two reads per bank per cycle.
`timescale 1ns / 1ps
`default_nettype none

module tbs_store import tbs_pkg::*; (
  input  wire logic                            clk,
  input  wire logic                            fire,
  input  wire issue_t                          issue,
  output logic [1:0][TEXEL_BITS-1:0]           even_data,
  output logic [1:0][TEXEL_BITS-1:0]           odd_data
);

  logic [TEXEL_BITS-1:0] bank_even [BANK_DEPTH];
  logic [TEXEL_BITS-1:0] bank_odd  [BANK_DEPTH];

  logic we;
  logic re;

  assign we = fire && (issue.op == OP_WRITE);
  assign re = fire && (issue.op == OP_SAMPLE);

  // Even bank: one write port, one read port per texture row
  always_ff @(posedge clk) begin
    if (we && !issue.waddr[0]) begin
      bank_even[issue.waddr[ADDR_BITS-1:1]] <= issue.wdata;
    end
    if (re) begin
      even_data[0] <= bank_even[issue.even_addr[0]];
      even_data[1] <= bank_even[issue.even_addr[1]];
    end
  end

  // Odd bank: same shape
  always_ff @(posedge clk) begin
    if (we && issue.waddr[0]) begin
      bank_odd[issue.waddr[ADDR_BITS-1:1]] <= issue.wdata;
    end
    if (re) begin
      odd_data[0] <= bank_odd[issue.odd_addr[0]];
      odd_data[1] <= bank_odd[issue.odd_addr[1]];
    end
  end

endmodule

`default_nettype wire

[rtl/tbs_front.sv]
// Front pipeline: coordinate scaling, texel position split, bank addresses and weights.
`timescale 1ns / 1ps
`default_nettype none

module tbs_front import tbs_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cfg_t                      cfg,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      op,
  input  wire logic [ADDR_BITS-1:0]      texel_addr,
  input  wire logic [CHANNEL_BITS-1:0]   texel_red,
  input  wire logic [CHANNEL_BITS-1:0]   texel_green,
  input  wire logic [CHANNEL_BITS-1:0]   texel_blue,
  input  wire logic [COORD_BITS-1:0]     u_coord,
  input  wire logic [COORD_BITS-1:0]     v_coord,
  output logic                           issue_valid,
  input  wire logic                      issue_ready,
  output issue_t                         issue
);

  function automatic logic [WT_BITS-1:0] weight_mul(logic [COORD_BITS-1:0] a,
                                                    logic [COORD_BITS-1:0] b);
    logic [2*COORD_BITS-1:0] p;
    p = (2 * COORD_BITS)'(a) * (2 * COORD_BITS)'(b);
    return p[WT_BITS-1:0];
  endfunction

  // Effective dimensions
  logic [DIM_BITS-1:0]   width_eff;
  logic [DIM_BITS-1:0]   height_eff;
  logic [DIM_BITS-1:0]   width_m1;
  logic [DIM_BITS-1:0]   height_m1;
  logic [COORD_BITS-1:0] u_sat;
  logic [COORD_BITS-1:0] v_sat;

  always_comb begin
    width_eff = cfg.tex_width;
    if (cfg.tex_width == '0) begin
      width_eff = DIM_MIN;
    end else if (cfg.tex_width > DIM_MAX) begin
      width_eff = DIM_MAX;
    end
    height_eff = cfg.tex_height;
    if (cfg.tex_height == '0) begin
      height_eff = DIM_MIN;
    end else if (cfg.tex_height > DIM_MAX) begin
      height_eff = DIM_MAX;
    end
    width_m1  = width_eff - DIM_MIN;
    height_m1 = height_eff - DIM_MIN;
    u_sat = (u_coord > ONE_COORD) ? ONE_COORD : u_coord;
    v_sat = (v_coord > ONE_COORD) ? ONE_COORD : v_coord;
  end

  // Stage registers
  logic                   v1, v2, v3;
  logic                   en1, en2, en3;
  logic                   op1, op2;
  logic [ADDR_BITS-1:0]   waddr1, waddr2;
  logic [TEXEL_BITS-1:0]  wdata1, wdata2;
  logic [POS_BITS-1:0]    pu1, pv1;
  logic [IDX_BITS-1:0]    u0_2, v0_2;
  logic [COORD_FRAC_BITS-1:0] fx2, fy2;
  issue_t                 issue_r;

  assign en3      = !v3 || issue_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // Stage 1: scale coordinates by dimension minus one
  always_ff @(posedge clk) begin
    if (en1) begin
      op1    <= op;
      waddr1 <= texel_addr;
      wdata1 <= {texel_red, texel_green, texel_blue};
      pu1    <= POS_BITS'(u_sat) * POS_BITS'(width_m1[IDX_BITS-1:0]);
      pv1    <= POS_BITS'(v_sat) * POS_BITS'(height_m1[IDX_BITS-1:0]);
    end
  end

  // Stage 2: split position into texel index and fraction, or round for nearest
  logic [POS_BITS-1:0]        pu_round, pv_round;
  logic [IDX_BITS-1:0]        u0_next, v0_next;
  logic [COORD_FRAC_BITS-1:0] fx_next, fy_next;

  always_comb begin
    pu_round = pu1 + HALF_POS;
    pv_round = pv1 + HALF_POS;
    if (cfg.filter_mode == MODE_BILINEAR) begin
      u0_next = pu1[COORD_FRAC_BITS +: IDX_BITS];
      v0_next = pv1[COORD_FRAC_BITS +: IDX_BITS];
      fx_next = pu1[COORD_FRAC_BITS-1:0];
      fy_next = pv1[COORD_FRAC_BITS-1:0];
    end else begin
      u0_next = pu_round[COORD_FRAC_BITS +: IDX_BITS];
      v0_next = pv_round[COORD_FRAC_BITS +: IDX_BITS];
      fx_next = '0;
      fy_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      op2    <= op1;
      waddr2 <= waddr1;
      wdata2 <= wdata1;
      u0_2   <= u0_next;
      v0_2   <= v0_next;
      fx2    <= fx_next;
      fy2    <= fy_next;
    end
  end

  // Stage 3: row addresses, bank split and corner weights
  logic [COORD_BITS-1:0]      gx, gy, fxw, fyw;
  logic [ADDR_BITS-1:0]       row_prod;
  logic [1:0][ADDR_BITS-1:0]  base;
  logic [1:0][ADDR_BITS-1:0]  right;
  issue_t                     issue_next;

  always_comb begin
    fxw = COORD_BITS'(fx2);
    fyw = COORD_BITS'(fy2);
    gx  = ONE_COORD - fxw;
    gy  = ONE_COORD - fyw;
    row_prod = ADDR_BITS'(v0_2) * ADDR_BITS'(width_eff);
    base[0]  = row_prod + ADDR_BITS'(u0_2);
    base[1]  = base[0] + ((fy2 != '0) ? ADDR_BITS'(width_eff) : '0);
    issue_next.op    = op2;
    issue_next.waddr = waddr2;
    issue_next.wdata = wdata2;
    for (int r = 0; r < 2; r++) begin
      right[r] = base[r] + ADDR_BITS'(1);
      // the odd texel of the pair always sits at base/2
      issue_next.odd_addr[r]  = base[r][ADDR_BITS-1:1];
      issue_next.even_addr[r] = base[r][0] ? right[r][ADDR_BITS-1:1]
                                           : base[r][ADDR_BITS-1:1];
      issue_next.base_odd[r]  = base[r][0];
    end
    issue_next.frac_x = (fx2 != '0);
    issue_next.wt[0]  = weight_mul(gx, gy);
    issue_next.wt[1]  = weight_mul(fxw, gy);
    issue_next.wt[2]  = weight_mul(gx, fyw);
    issue_next.wt[3]  = weight_mul(fxw, fyw);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      issue_r <= issue_next;
    end
  end

  assign issue_valid = v3;
  assign issue       = issue_r;

endmodule

`default_nettype wire

[rtl/tbs_blend.sv]
// Back pipeline: corner select, weighted products, sum with rounding, output register.
`timescale 1ns / 1ps
`default_nettype none

module tbs_blend import tbs_pkg::*; (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            issue_valid,
  output logic                                 issue_ready,
  input  wire issue_t                          issue,
  input  wire logic [1:0][TEXEL_BITS-1:0]      even_data,
  input  wire logic [1:0][TEXEL_BITS-1:0]      odd_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [CHANNEL_BITS-1:0]              red,
  output logic [CHANNEL_BITS-1:0]              green,
  output logic [CHANNEL_BITS-1:0]              blue
);

  logic v4, v5, v6;
  logic en4, en5, en6;

  logic [1:0]               base_odd4;
  logic                     frac_x4;
  logic [3:0][WT_BITS-1:0]  wt4;

  logic [2:0][3:0][PROD_BITS-1:0]    prod5;
  logic [2:0][CHANNEL_BITS-1:0]      pix6;

  assign en6         = !v6 || out_ready;
  assign en5         = !v5 || en6;
  assign en4         = !v4 || en5;
  assign issue_ready = en4;

  // Only samples continue past the memory; write words end there
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en4) v4 <= issue_valid && (issue.op == OP_SAMPLE);
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  // Stage 4: sideband that travels with the memory read
  always_ff @(posedge clk) begin
    if (en4) begin
      base_odd4 <= issue.base_odd;
      frac_x4   <= issue.frac_x;
      wt4       <= issue.wt;
    end
  end

  // Pick the four corners out of the banks
  logic [1:0][TEXEL_BITS-1:0] left_tx;
  logic [1:0][TEXEL_BITS-1:0] right_tx;
  logic [3:0][TEXEL_BITS-1:0] corner;
  logic [2:0][3:0][PROD_BITS-1:0] prod_next;
  logic [MUL_BITS-1:0]        mul;

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      left_tx[r]  = base_odd4[r] ? odd_data[r] : even_data[r];
      right_tx[r] = frac_x4 ? (base_odd4[r] ? even_data[r] : odd_data[r]) : left_tx[r];
    end
    corner[0] = left_tx[0];
    corner[1] = right_tx[0];
    corner[2] = left_tx[1];
    corner[3] = right_tx[1];
    mul = '0;
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 4; k++) begin
        mul = MUL_BITS'(corner[k][c*CHANNEL_BITS +: CHANNEL_BITS]) * MUL_BITS'(wt4[k]);
        // weighted channel stays below 2^48
        prod_next[c][k] = mul[PROD_BITS-1:0];
      end
    end
  end

  // Stage 5: products
  always_ff @(posedge clk) begin
    if (en5) begin
      prod5 <= prod_next;
    end
  end

  // Stage 6: sum the corners, round half up, drop the weight fraction
  logic [2:0][PROD_BITS-1:0]    acc;
  logic [2:0][CHANNEL_BITS-1:0] pix_next;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = prod5[c][0] + prod5[c][1] + prod5[c][2] + prod5[c][3] + ROUND_HALF;
      pix_next[c] = acc[c][2*COORD_FRAC_BITS +: CHANNEL_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      pix6 <= pix_next;
    end
  end

  assign out_valid = v6;
  assign red       = pix6[CH_RED];
  assign green     = pix6[CH_GREEN];
  assign blue      = pix6[CH_BLUE];

  // Checks
  logic [WT_BITS:0] wt_sum;
  assign wt_sum = (WT_BITS + 1)'(wt4[0]) + (WT_BITS + 1)'(wt4[1])
                + (WT_BITS + 1)'(wt4[2]) + (WT_BITS + 1)'(wt4[3]);

  a_wt_unity: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (wt_sum == (WT_BITS + 1)'(WT_ONE)))
    else $error("corner weights of a sample do not add up to one");

  a_no_right_wt: assert property (@(posedge clk) disable iff (rst)
    (v4 && !frac_x4) |-> ((wt4[1] == '0) && (wt4[3] == '0)))
    else $error("right column weighted although the fraction is zero");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (v4 && en5) |=> v5)
    else $error("sample lost between memory and product stage");

endmodule

`default_nettype wire

[rtl/texture_bilinear_sampler.sv]
// Top level: register port, front pipeline, banked texel store and blend pipeline.
//
// Usage:
//   Input words (in_valid/in_ready) are either texel writes (op = write) that
//   load one RGB texel at texel_addr, or samples (op = sample) at a Q1.16
//   coordinate pair u_coord, v_coord. Writes give no output word; each sample
//   gives one word of red, green, blue on out_valid/out_ready.
//   Registers tex_width (0x0), tex_height (0x4) and filter_mode (0x8) are
//   written over the APB port; the user must write them only while no item
//   is in flight, which the block itself does not enforce. Throughput: one
//   word per cycle while out_ready does not stall the output. The store is
//   split into even and odd banks, each with one write port and two read
//   ports, so the four corner texels of a sample are read in the same cycle.
//   Stall: when out_ready is low the result holds in the output register and
//   the six-stage pipeline keeps taking words until every stage is full.
//   Reset: registers return to 256 x 256, bilinear; the pipeline empties.
//   The texel store is not cleared: read only texels that were written.
`timescale 1ns / 1ps
`default_nettype none

module texture_bilinear_sampler import tbs_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0]    paddr,
  input  wire logic [CFG_DATA_BITS-1:0]    pwdata,
  output logic [CFG_DATA_BITS-1:0]         prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        op,
  input  wire logic [ADDR_BITS-1:0]        texel_addr,
  input  wire logic [CHANNEL_BITS-1:0]     texel_red,
  input  wire logic [CHANNEL_BITS-1:0]     texel_green,
  input  wire logic [CHANNEL_BITS-1:0]     texel_blue,
  input  wire logic [COORD_BITS-1:0]       u_coord,
  input  wire logic [COORD_BITS-1:0]       v_coord,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [CHANNEL_BITS-1:0]          red,
  output logic [CHANNEL_BITS-1:0]          green,
  output logic [CHANNEL_BITS-1:0]          blue
);

  cfg_t     cfg;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tex_width   <= DIM_RESET;
      cfg.tex_height  <= DIM_RESET;
      cfg.filter_mode <= MODE_BILINEAR;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_TEX_WIDTH:   cfg.tex_width   <= pwdata[DIM_BITS-1:0];
        REG_TEX_HEIGHT:  cfg.tex_height  <= pwdata[DIM_BITS-1:0];
        REG_FILTER_MODE: cfg.filter_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      REG_TEX_WIDTH:   prdata = CFG_DATA_BITS'(cfg.tex_width);
      REG_TEX_HEIGHT:  prdata = CFG_DATA_BITS'(cfg.tex_height);
      REG_FILTER_MODE: prdata = CFG_DATA_BITS'(cfg.filter_mode);
      default:         prdata = '0;
    endcase
  end

  logic                       issue_valid;
  logic                       issue_ready;
  logic                       fire;
  issue_t                     issue;
  logic [1:0][TEXEL_BITS-1:0] even_data;
  logic [1:0][TEXEL_BITS-1:0] odd_data;

  // Writes and reads leave the same stage in order, so no forwarding is needed
  assign fire = issue_valid && issue_ready;

  tbs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .texel_addr  (texel_addr),
    .texel_red   (texel_red),
    .texel_green (texel_green),
    .texel_blue  (texel_blue),
    .u_coord     (u_coord),
    .v_coord     (v_coord),
    .issue_valid (issue_valid),
    .issue_ready (issue_ready),
    .issue       (issue)
  );

  tbs_store u_store (
    .clk       (clk),
    .fire      (fire),
    .issue     (issue),
    .even_data (even_data),
    .odd_data  (odd_data)
  );

  tbs_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .issue_valid (issue_valid),
    .issue_ready (issue_ready),
    .issue       (issue),
    .even_data   (even_data),
    .odd_data    (odd_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );

endmodule

`default_nettype wire

[dv/tb_texture_bilinear_sampler.sv]
// Testbench for texture_bilinear_sampler: self-checking texel filter regression.
`timescale 1ns / 1ps

module tb_texture_bilinear_sampler;
  import tbs_pkg::*;

  localparam int NUM_PHASES      = 12;
  localparam int WORDS_PER_PHASE = 140;
  localparam int HOLD_PHASE      = 8;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 12;
  localparam int STALL_LIMIT     = 3000;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } rgb_t;

  typedef struct {
    int   seq;
    rgb_t rgb;
  } color_due_t;

  // Own copy of the texel store and registers; predicts each sample's color
  class filtered_color_board;
    logic [TEXEL_BITS-1:0] texels [2**ADDR_BITS];
    logic [DIM_BITS-1:0]   width_reg;
    logic [DIM_BITS-1:0]   height_reg;
    logic                  mode_reg;
    color_due_t            colors_due [$];
    int                    mismatches;
    int                    writes_seen;
    int                    samples_seen;
    int                    samples_checked;

    function new();
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      mode_reg   = MODE_BILINEAR;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        REG_TEX_WIDTH:   width_reg  = val[DIM_BITS-1:0];
        REG_TEX_HEIGHT:  height_reg = val[DIM_BITS-1:0];
        REG_FILTER_MODE: mode_reg   = val[0];
        default: ;
      endcase
    endfunction

    function logic [DIM_BITS-1:0] eff_dim(logic [DIM_BITS-1:0] d);
      if (d == '0) return DIM_MIN;
      if (d > DIM_MAX) return DIM_MAX;
      return d;
    endfunction

    // Corner addresses (u0v0, u1v0, u0v1, u1v1) and axis weights of a sample;
    // nearest mode puts full weight on one texel
    function void footprint(input logic [COORD_BITS-1:0] u, v,
                            output logic [3:0][ADDR_BITS-1:0] corner,
                            output logic [1:0][COORD_BITS-1:0] wx,
                            output logic [1:0][COORD_BITS-1:0] wy);
      logic [DIM_BITS-1:0]   w, h;
      logic [COORD_BITS-1:0] uc, vc;
      logic [POS_BITS-1:0]   pu, pv, u0, u1, v0, v1;
      w  = eff_dim(width_reg);
      h  = eff_dim(height_reg);
      uc = (u > ONE_COORD) ? ONE_COORD : u;
      vc = (v > ONE_COORD) ? ONE_COORD : v;
      pu = uc * (w - 1'b1);
      pv = vc * (h - 1'b1);
      if (mode_reg == MODE_NEAREST) begin
        u0 = (pu + HALF_POS) >> COORD_FRAC_BITS;
        v0 = (pv + HALF_POS) >> COORD_FRAC_BITS;
        u1 = u0;
        v1 = v0;
        wx[0] = ONE_COORD;
        wx[1] = '0;
        wy[0] = ONE_COORD;
        wy[1] = '0;
      end else begin
        u0 = pu >> COORD_FRAC_BITS;
        v0 = pv >> COORD_FRAC_BITS;
        wx[1] = COORD_BITS'(pu[COORD_FRAC_BITS-1:0]);
        wy[1] = COORD_BITS'(pv[COORD_FRAC_BITS-1:0]);
        wx[0] = ONE_COORD - wx[1];
        wy[0] = ONE_COORD - wy[1];
        u1 = u0 + POS_BITS'(wx[1] != '0);
        v1 = v0 + POS_BITS'(wy[1] != '0);
      end
      corner[0] = ADDR_BITS'(v0 * w + u0);
      corner[1] = ADDR_BITS'(v0 * w + u1);
      corner[2] = ADDR_BITS'(v1 * w + u0);
      corner[3] = ADDR_BITS'(v1 * w + u1);
    endfunction

    // Store a texel write, or predict the color of a sample
    function void note_word(logic is_sample, logic [ADDR_BITS-1:0] addr,
                            logic [TEXEL_BITS-1:0] texel, logic [COORD_BITS-1:0] u, v);
      logic [3:0][ADDR_BITS-1:0]     corner;
      logic [1:0][COORD_BITS-1:0]    wx, wy;
      logic [2:0][CHANNEL_BITS-1:0]  blended;
      logic [63:0]                   acc;
      color_due_t                    due;
      if (is_sample == OP_WRITE) begin
        texels[addr] = texel;
        writes_seen++;
        return;
      end
      footprint(u, v, corner, wx, wy);
      for (int ch = 0; ch < 3; ch++) begin
        acc = '0;
        for (int k = 0; k < 4; k++)
          acc = acc + texels[corner[k]][ch*CHANNEL_BITS +: CHANNEL_BITS] * wx[k%2] * wy[k/2];
        acc = (acc + 64'(ROUND_HALF)) >> (2 * COORD_FRAC_BITS);
        blended[ch] = acc[CHANNEL_BITS-1:0];
      end
      due.seq       = samples_seen;
      due.rgb.red   = blended[CH_RED];
      due.rgb.green = blended[CH_GREEN];
      due.rgb.blue  = blended[CH_BLUE];
      colors_due.push_back(due);
      samples_seen++;
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    // Compare an output word with the oldest predicted color
    task check_color(rgb_t got);
      color_due_t due;
      if (colors_due.size() == 0) begin
        flag_mismatch($sformatf("color %h/%h/%h with no sample waiting",
                                got.red, got.green, got.blue));
        return;
      end
      due = colors_due.pop_front();
      samples_checked++;
      if (got.red !== due.rgb.red)
        flag_mismatch($sformatf("sample %0d red %h, want %h", due.seq, got.red, due.rgb.red));
      if (got.green !== due.rgb.green)
        flag_mismatch($sformatf("sample %0d green %h, want %h", due.seq, got.green,
                                due.rgb.green));
      if (got.blue !== due.rgb.blue)
        flag_mismatch($sformatf("sample %0d blue %h, want %h", due.seq, got.blue, due.rgb.blue));
    endtask

    function int pending();
      return colors_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = OP_WRITE;
  logic [ADDR_BITS-1:0] texel_addr = '0;
  logic [CHANNEL_BITS-1:0] texel_red = '0;
  logic [CHANNEL_BITS-1:0] texel_green = '0;
  logic [CHANNEL_BITS-1:0] texel_blue = '0;
  logic [COORD_BITS-1:0] u_coord = '0;
  logic [COORD_BITS-1:0] v_coord = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  filtered_color_board board;
  bit texel_known [2**ADDR_BITS];
  int send_idle = 0;
  int recv_idle = 0;
  int words_sent = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;

  texture_bilinear_sampler dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .texel_addr (texel_addr),
    .texel_red  (texel_red),
    .texel_green(texel_green),
    .texel_blue (texel_blue),
    .u_coord    (u_coord),
    .v_coord    (v_coord),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, or a long counted hold-off when requested
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Note accepted input words and check accepted output words
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        board.note_word(op, texel_addr, {texel_red, texel_green, texel_blue}, u_coord, v_coord);
      if (out_valid && out_ready)
        board.check_color({red, green, blue});
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles, %0d colors outstanding",
                 $realtime, STALL_LIMIT, board.pending());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic [CHANNEL_BITS-1:0] rand_chan();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return CHANNEL_BITS'($urandom);
    endcase
  endfunction

  // Coordinates: edges, above 1.0, grid-aligned steps, tiny and random fractions
  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(9))
      0: return '0;
      1: return ONE_COORD;
      2: return COORD_BITS'($urandom_range(2**COORD_BITS - 1, 2**COORD_FRAC_BITS + 1));
      3: return COORD_BITS'($urandom_range(255));
      4: return COORD_BITS'($urandom_range(16) * 4096);
      default: return COORD_BITS'($urandom_range(2**COORD_FRAC_BITS));
    endcase
  endfunction

  // Offer one word after a random gap; return once it is accepted
  task automatic send_word(logic kind, logic [ADDR_BITS-1:0] addr,
                           logic [TEXEL_BITS-1:0] texel, logic [COORD_BITS-1:0] u, v);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op          <= kind;
    texel_addr  <= addr;
    texel_red   <= texel[CH_RED*CHANNEL_BITS +: CHANNEL_BITS];
    texel_green <= texel[CH_GREEN*CHANNEL_BITS +: CHANNEL_BITS];
    texel_blue  <= texel[CH_BLUE*CHANNEL_BITS +: CHANNEL_BITS];
    u_coord     <= u;
    v_coord     <= v;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic put_texel(logic [ADDR_BITS-1:0] addr, logic [TEXEL_BITS-1:0] texel);
    send_word(OP_WRITE, addr, texel, COORD_BITS'($urandom), COORD_BITS'($urandom));
    texel_known[addr] = 1'b1;
  endtask

  // Load any corner not yet written (and refresh some), then sample
  task automatic sample_at(logic [COORD_BITS-1:0] u, v);
    logic [3:0][ADDR_BITS-1:0]  corner;
    logic [1:0][COORD_BITS-1:0] wx, wy;
    board.footprint(u, v, corner, wx, wy);
    for (int k = 0; k < 4; k++)
      if (!texel_known[corner[k]] || $urandom_range(7) == 0)
        put_texel(corner[k], {rand_chan(), rand_chan(), rand_chan()});
    send_word(OP_SAMPLE, ADDR_BITS'($urandom), TEXEL_BITS'({$urandom, $urandom}), u, v);
  endtask

  // Drop valid, wait for every color, then let trailing writes retire
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Register setting of each phase; out-of-range dimensions included
  task automatic phase_setting(int p, output logic [DIM_BITS-1:0] w, h, output logic mode);
    case (p)
      1:  begin w = 9'd1;   h = 9'd1;   mode = MODE_NEAREST;  end
      2:  begin w = 9'd0;   h = 9'd0;   mode = MODE_BILINEAR; end
      3:  begin w = 9'd17;  h = 9'd17;  mode = MODE_BILINEAR; end
      4:  begin w = 9'd511; h = 9'd300; mode = MODE_NEAREST;  end
      5:  begin w = 9'd2;   h = 9'd3;   mode = MODE_BILINEAR; end
      6:  begin w = 9'd256; h = 9'd1;   mode = MODE_BILINEAR; end
      7:  begin w = 9'd1;   h = 9'd256; mode = MODE_NEAREST;  end
      8:  begin w = 9'd5;   h = 9'd129; mode = MODE_BILINEAR; end
      9:  begin w = 9'd257; h = 9'd9;   mode = MODE_NEAREST;  end
      10: begin
        w    = DIM_BITS'($urandom_range(40, 1));
        h    = DIM_BITS'($urandom_range(40, 1));
        mode = 1'($urandom);
      end
      default: begin w = 9'd256; h = 9'd256; mode = MODE_BILINEAR; end
    endcase
  endtask

  task automatic run_phase(int p);
    logic [DIM_BITS-1:0] w, h;
    logic                mode;
    logic [CFG_DATA_BITS-1:0] junk;
    int                  stop_at;
    if (p < 4) begin
      send_idle = 37;
      recv_idle = 50;
    end else if (p < 8) begin
      send_idle = 50;
      recv_idle = 37;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    if (p == 0) begin
      // Reset setting 256 x 256 bilinear: store corners, both edges, saturation
      put_texel('0, '1);
      put_texel('1, '0);
      sample_at('0, '0);
      sample_at(ONE_COORD, ONE_COORD);
      sample_at('1, '1);
      sample_at(COORD_BITS'(1), COORD_BITS'(1));
      sample_at(ONE_COORD - 1'b1, ONE_COORD - 1'b1);
      sample_at(ONE_COORD, '0);
      sample_at('0, ONE_COORD);
    end else begin
      drain();
      phase_setting(p, w, h, mode);
      // Upper bits beyond each field are ignored by the block
      junk = ($urandom_range(3) == 0) ? $urandom : '0;
      reg_write(REG_TEX_WIDTH, {junk[CFG_DATA_BITS-1:DIM_BITS], w});
      reg_write(REG_TEX_HEIGHT, {junk[CFG_DATA_BITS-1:DIM_BITS], h});
      reg_write(REG_FILTER_MODE, {junk[CFG_DATA_BITS-1:1], mode});
    end
    if (p == HOLD_PHASE) hold_request = 1'b1;
    stop_at = words_sent + WORDS_PER_PHASE;
    while (words_sent < stop_at) begin
      if ($urandom_range(99) < 75)
        sample_at(rand_coord(), rand_coord());
      else
        put_texel(ADDR_BITS'($urandom), {rand_chan(), rand_chan(), rand_chan()});
    end
  endtask

  initial begin
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < NUM_PHASES; p++) run_phase(p);
    drain();
    $display("Covered %0d texel writes and %0d samples over %0d register settings,",
             board.writes_seen, board.samples_checked, NUM_PHASES);
    $display("both filter modes, clamped and saturated inputs, and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
